[sv/jsu_pkg.sv]
// jsu_pkg: shared types and constants of the json string unescaper
// used by jsu_front, jsu_queue, jsu_back and the top level; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

   // width of the per-string output byte counter
   localparam int COUNT_WIDTH = 16;
   // width of the limit compare: wide enough for the register and the counter
   localparam int LIM_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

   // most data bytes one input word can produce
   localparam int MAX_DATA = 4;
   localparam int DIDX_W   = $clog2(MAX_DATA);
   localparam int DCNT_W   = $clog2(MAX_DATA + 1);

   // queue between front and back, power of two deep
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // input word
   typedef struct packed {
      logic [7:0] text_byte;
      logic       text_end;
   } req_payload_type;

   // result word
   typedef struct packed {
      logic [7:0] plain_byte;
      logic       final_mark;
   } rsp_payload_type;

   // one queue entry: the data bytes of one input word and the string end flag
   typedef struct packed {
      logic [MAX_DATA-1:0][7:0] data;
      logic [DCNT_W-1:0]        count;
      logic                     last;
   } entry_type;

   // queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

`default_nettype wire

[sv/json_string_unescape_utf8_top.sv]
// json_string_unescape_utf8_top: json string unescaper with utf-8 output
// holds the limit register; depends on jsu_pkg, jsu_front, jsu_queue, jsu_back
//
//   port group   dir   handshake             word
//   req_         in    req_valid/req_stall   req_payload (text_byte, text_end)
//   rsp_         out   rsp_valid/rsp_stall   rsp_payload (plain_byte, final_mark)
//   csr_         in    csr_valid/csr_ready   csr_wdata (output_limit)
//
// one input word is taken per cycle while the four-entry queue has room
// each result leaves the output register one per cycle unless rsp_stall holds it,
// and a word yields up to four data bytes plus the terminator
// the first result of a word is registered in the queue and then in the output register
// reset is synchronous; csr_ready is always high and output_limit resets to 65535
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape_utf8_top import jsu_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire req_payload_type req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output rsp_payload_type      rsp_payload,
   input  wire logic            csr_valid,
   output logic                 csr_ready,
   input  wire logic [15:0]     csr_wdata
);

   logic [15:0]  limit_ff, limit_in;
   logic         push;
   logic         pop;
   entry_type    push_entry;
   entry_type    head;
   q_status_type q_status;

   // limit register
   assign csr_ready = 1'b1;
   assign limit_in  = (csr_valid && csr_ready) ? csr_wdata : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= 16'hFFFF;
      end else begin
         limit_ff <= limit_in;
      end
   end

   jsu_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .output_limit (limit_ff),
      .q_status     (q_status),
      .push         (push),
      .entry        (push_entry)
   );

   jsu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   jsu_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .q_status    (q_status),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

[sv/jsu_front.sv]
// jsu_front: escape parser; takes one input word per cycle while the queue has
// room and turns it into a queue entry of up to four bytes; depends on jsu_pkg
`timescale 1ns / 1ps
`default_nettype none

module jsu_front import jsu_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire req_payload_type req_payload,
   input  wire logic [15:0]     output_limit,
   input  wire q_status_type    q_status,
   output logic                 push,
   output entry_type            entry
);

   typedef enum logic [1:0] {
      MODE_PLAIN = 2'd0,
      MODE_ESC   = 2'd1,
      MODE_HEX   = 2'd2
   } mode_type;

   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_U      = 8'h75;
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] LEAD2     = 8'hC0;
   localparam logic [7:0] LEAD3     = 8'hE0;
   localparam logic [7:0] CONT      = 8'h80;
   localparam logic [15:0] ONE_BYTE_END = 16'h0080;
   localparam logic [15:0] TWO_BYTE_END = 16'h0800;
   localparam int HELD_DEPTH = 3;

   localparam logic [LIM_W-1:0] CNT_MAX = LIM_W'({COUNT_WIDTH{1'b1}});

   // escaped character to its byte; anything unknown passes through
   function automatic logic [7:0] esc_map(input logic [7:0] c);
      logic [7:0] r;
      unique case (c)
         CH_B:    r = CH_BS;
         CH_F:    r = CH_FF;
         CH_N:    r = CH_LF;
         CH_R:    r = CH_CR;
         CH_T:    r = CH_TAB;
         default: r = c;
      endcase
      return r;
   endfunction

   // hex digit decode: {is_digit, value}
   function automatic logic [4:0] hex_val(input logic [7:0] c);
      logic [4:0] r;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         r = {1'b1, 4'(c[3:0] + 4'd9)};
      end else begin
         r = 5'd0;
      end
      return r;
   endfunction

   mode_type                 mode_ff, mode_in;
   logic [1:0]               seen_ff, seen_in;
   logic [7:0]               held_ff [HELD_DEPTH];
   logic [7:0]               held_in [HELD_DEPTH];
   logic [15:0]              code_ff, code_in;
   logic                     hv_ff, hv_in;
   logic [COUNT_WIDTH-1:0]   bw_ff, bw_in;

   logic                     accept;
   logic [7:0]               b;
   logic                     last_in;
   logic [LIM_W-1:0]         limit_ext;
   logic [LIM_W-1:0]         cap;
   logic [LIM_W-1:0]         room;
   logic [DCNT_W-1:0]        nb;
   logic [MAX_DATA-1:0][7:0] out_b;
   logic [4:0]               hd;
   logic [15:0]              cp;
   mode_type                 rmode;
   logic [7:0]               rc;
   logic                     rlast;

   assign accept    = req_valid && !q_status.full;
   assign req_stall = q_status.full;
   assign b         = req_payload.text_byte;
   assign last_in   = req_payload.text_end;

   // limit in effect and bytes still allowed in this string, zero once reached
   assign limit_ext = LIM_W'(output_limit);
   assign cap       = (limit_ext < CNT_MAX) ? limit_ext : CNT_MAX;
   assign room      = (LIM_W'(bw_ff) >= cap) ? '0 : cap - LIM_W'(bw_ff);

   // parse one word
   always_comb begin
      mode_in = mode_ff;
      seen_in = seen_ff;
      held_in = held_ff;
      code_in = code_ff;
      hv_in   = hv_ff;
      bw_in   = bw_ff;
      nb      = '0;
      out_b   = '0;
      hd      = hex_val(b);
      cp      = '0;
      rmode   = MODE_PLAIN;
      rc      = '0;
      rlast   = 1'b0;
      if (accept) begin
         unique case (mode_ff)
            MODE_ESC: begin
               mode_in = MODE_PLAIN;
               if (b == CH_U && !last_in) begin
                  mode_in = MODE_HEX;
                  seen_in = '0;
                  code_in = '0;
                  hv_in   = 1'b1;
               end else begin
                  out_b[nb[DIDX_W-1:0]] = esc_map(b);
                  nb = nb + DCNT_W'(1);
               end
            end
            MODE_HEX: begin
               // value stops growing at the first non-hex character
               if (hv_ff && hd[4]) begin
                  code_in = {code_ff[11:0], hd[3:0]};
               end else begin
                  hv_in = 1'b0;
               end
               cp = code_in;
               if (seen_ff == 2'd3) begin
                  // fourth character: emit utf-8, multi-byte only if it fits whole
                  mode_in = MODE_PLAIN;
                  seen_in = '0;
                  if (cp < ONE_BYTE_END) begin
                     out_b[nb[DIDX_W-1:0]] = cp[7:0];
                     nb = nb + DCNT_W'(1);
                  end else if (cp < TWO_BYTE_END) begin
                     if (room > LIM_W'(1)) begin
                        out_b[nb[DIDX_W-1:0]] = LEAD2 | {3'd0, cp[10:6]};
                        nb = nb + DCNT_W'(1);
                        out_b[nb[DIDX_W-1:0]] = CONT | {2'd0, cp[5:0]};
                        nb = nb + DCNT_W'(1);
                     end
                  end else if (room > LIM_W'(2)) begin
                     out_b[nb[DIDX_W-1:0]] = LEAD3 | {4'd0, cp[15:12]};
                     nb = nb + DCNT_W'(1);
                     out_b[nb[DIDX_W-1:0]] = CONT | {2'd0, cp[11:6]};
                     nb = nb + DCNT_W'(1);
                     out_b[nb[DIDX_W-1:0]] = CONT | {2'd0, cp[5:0]};
                     nb = nb + DCNT_W'(1);
                  end
               end else if (last_in) begin
                  // short unicode escape: 'u', then the held characters as text
                  mode_in = MODE_PLAIN;
                  seen_in = '0;
                  out_b[nb[DIDX_W-1:0]] = CH_U;
                  nb = nb + DCNT_W'(1);
                  for (int k = 0; k < HELD_DEPTH; k++) begin
                     if (2'(k) <= seen_ff) begin
                        rlast = (2'(k) == seen_ff);
                        rc    = rlast ? b : held_ff[2'(k)];
                        case (rmode)
                           MODE_ESC: begin
                              rmode = MODE_PLAIN;
                              if (rc == CH_U && !rlast) begin
                                 rmode = MODE_HEX;
                              end else begin
                                 out_b[nb[DIDX_W-1:0]] = esc_map(rc);
                                 nb = nb + DCNT_W'(1);
                              end
                           end
                           MODE_HEX: begin
                              // nested short escape, always on the last character
                              rmode = MODE_PLAIN;
                              out_b[nb[DIDX_W-1:0]] = CH_U;
                              nb = nb + DCNT_W'(1);
                              if (room > LIM_W'(nb)) begin
                                 out_b[nb[DIDX_W-1:0]] = rc;
                                 nb = nb + DCNT_W'(1);
                              end
                           end
                           default: begin
                              if (room > LIM_W'(nb)) begin
                                 if (rc == CH_BSLASH && !rlast) begin
                                    rmode = MODE_ESC;
                                 end else begin
                                    out_b[nb[DIDX_W-1:0]] = rc;
                                    nb = nb + DCNT_W'(1);
                                 end
                              end
                           end
                        endcase
                     end
                  end
               end else begin
                  held_in[seen_ff] = b;
                  seen_in = seen_ff + 2'd1;
               end
            end
            default: begin
               // plain text; bytes past the limit are dropped
               mode_in = MODE_PLAIN;
               if (room != '0) begin
                  if (b == CH_BSLASH && !last_in) begin
                     mode_in = MODE_ESC;
                  end else begin
                     out_b[nb[DIDX_W-1:0]] = b;
                     nb = nb + DCNT_W'(1);
                  end
               end
            end
         endcase
         // string end clears the per-string state
         if (last_in) begin
            mode_in = MODE_PLAIN;
            seen_in = '0;
            code_in = '0;
            hv_in   = 1'b1;
            bw_in   = '0;
         end else begin
            bw_in = bw_ff + COUNT_WIDTH'(nb);
         end
      end
   end

   // queue entry for the back end
   assign push        = accept && (nb != '0 || last_in);
   assign entry.data  = out_b;
   assign entry.count = nb;
   assign entry.last  = last_in;

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_PLAIN;
         seen_ff <= '0;
         code_ff <= '0;
         hv_ff   <= 1'b1;
         bw_ff   <= '0;
      end else begin
         mode_ff <= mode_in;
         seen_ff <= seen_in;
         code_ff <= code_in;
         hv_ff   <= hv_in;
         bw_ff   <= bw_in;
         held_ff <= held_in;
      end
   end

`ifndef SYNTHESIS
   // a string end leaves the parser clean
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      accept && last_in |=> mode_ff == MODE_PLAIN && bw_ff == '0 && seen_ff == '0)
      else $error("per-string state not cleared after string end");
   // the hex counter only moves inside a unicode escape
   a_seen_idle: assert property (@(posedge clock) disable iff (reset)
      mode_ff != MODE_HEX |-> seen_ff == '0)
      else $error("hex count nonzero outside unicode escape");
   // an escape lasts exactly one character
   a_esc_once: assert property (@(posedge clock) disable iff (reset)
      accept && mode_ff == MODE_ESC |=> mode_ff != MODE_ESC)
      else $error("escape mode held over two characters");
`endif

endmodule

`default_nettype wire

[sv/jsu_queue.sv]
// jsu_queue: short entry queue between parser and output sequencer
// depends on jsu_pkg
`timescale 1ns / 1ps
`default_nettype none

module jsu_queue import jsu_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_entry,
   input  wire logic      pop,
   output entry_type      head,
   output q_status_type   status
);

   entry_type         store_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in;
   logic [QPTR_W-1:0] rd_ff, rd_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;

   // pointer and fill count update
   always_comb begin
      wr_in  = push ? wr_ff + QPTR_W'(1) : wr_ff;
      rd_in  = pop ? rd_ff + QPTR_W'(1) : rd_ff;
      cnt_in = cnt_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ff] <= push_entry;
      end
   end

   assign head         = store_ff[rd_ff];
   assign status.full  = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (cnt_ff == '0);

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full || pop)
      else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("pop from empty queue");
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + QCNT_W'(1))
      else $error("fill count lost a push");
`endif

endmodule

`default_nettype wire

[sv/jsu_back.sv]
// jsu_back: output sequencer, needs jsu_pkg; holds the result register, walks
// the head entry one byte a cycle unless stalled, adds string end terminator
`timescale 1ns / 1ps
`default_nettype none

module jsu_back import jsu_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire entry_type    head,
   input  wire q_status_type q_status,
   output logic              pop,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_payload_type   rsp_payload
);

   logic [DCNT_W-1:0] idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_payload_ff, rsp_payload_in;
   logic              slot_free;
   logic              load;
   logic              done;

   // result register is free when empty or being taken
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign load      = slot_free && !q_status.empty;

   // pick the next byte of the head entry, or its terminator
   always_comb begin
      rsp_payload_in = rsp_payload_ff;
      rsp_valid_in   = rsp_valid_ff && !slot_free;
      idx_in         = idx_ff;
      done           = 1'b0;
      if (load) begin
         rsp_valid_in = 1'b1;
         if (idx_ff < head.count) begin
            rsp_payload_in.plain_byte = head.data[idx_ff[DIDX_W-1:0]];
            rsp_payload_in.final_mark = 1'b0;
            done = (idx_ff + DCNT_W'(1) == head.count) && !head.last;
         end else begin
            rsp_payload_in.plain_byte = '0;
            rsp_payload_in.final_mark = 1'b1;
            done = 1'b1;
         end
         idx_in = done ? '0 : idx_ff + DCNT_W'(1);
      end
   end

   assign pop = load && done;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef SYNTHESIS
   // a partly sent entry stays at the head
   a_mid_entry: assert property (@(posedge clock) disable iff (reset)
      idx_ff != '0 |-> !q_status.empty)
      else $error("entry left the queue before all bytes were sent");
   // a free slot with work pending is always filled
   a_fill: assert property (@(posedge clock) disable iff (reset)
      !q_status.empty && slot_free |=> rsp_valid_ff)
      else $error("result register left empty with entries queued");
   // nothing is popped without its last result being loaded
   a_pop_load: assert property (@(posedge clock) disable iff (reset)
      pop |-> slot_free && (head.last ? idx_ff == head.count
                                      : idx_ff + DCNT_W'(1) == head.count))
      else $error("entry popped early");
`endif

endmodule

`default_nettype wire

[test/json_string_unescape_utf8_top_test.sv]
// json_string_unescape_utf8_top_test: self-checking bench for the json string unescaper
// drives escaped string bytes, predicts the unescaped utf-8 words; depends on jsu_pkg
`timescale 1ns / 1ps

module json_string_unescape_utf8_top_test;
   import jsu_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 12;
   localparam int HOLD_CYCLES    = 80;
   localparam int PHASE_WORDS    = 30;
   localparam int PHASES         = 7;

   localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
   localparam logic [7:0] CH_QUOTE      = 8'h22;
   localparam logic [7:0] CH_SLASH      = 8'h2F;
   localparam logic [7:0] CH_U          = 8'h75;
   localparam logic [7:0] CTL_BACKSPACE = 8'h08;
   localparam logic [7:0] CTL_FORMFEED  = 8'h0C;
   localparam logic [7:0] CTL_NEWLINE   = 8'h0A;
   localparam logic [7:0] CTL_RETURN    = 8'h0D;
   localparam logic [7:0] CTL_TAB       = 8'h09;

   localparam rsp_payload_type TERMINATOR = '{plain_byte: 8'h00, final_mark: 1'b1};

   typedef enum logic [1:0] {MODE_TEXT, MODE_ESCAPE, MODE_HEX} parse_mode_type;

   // directed word: when given is set, the n data bytes in want (byte 0 lowest) are the
   // expected words, plus the terminator on a string end; otherwise the predictor decides
   typedef struct packed {
      logic [7:0]  text_byte;
      logic        text_end;
      logic        given;
      logic [2:0]  n;
      logic [31:0] want;
   } probe_row_type;

   localparam probe_row_type PROBES [25] = '{
      '{8'h00,        1'b0, 1'b1, 3'd1, 32'h0000_0000},  // zero byte is plain data
      '{8'hFF,        1'b1, 1'b1, 3'd1, 32'h0000_00FF},  // top byte ends the string
      '{CH_BACKSLASH, 1'b0, 1'b1, 3'd0, 32'h0},
      '{"n",          1'b0, 1'b1, 3'd1, 32'h0000_000A},  // newline
      '{CH_BACKSLASH, 1'b0, 1'b1, 3'd0, 32'h0},
      '{"q",          1'b0, 1'b1, 3'd1, 32'h0000_0071},  // unknown escape passes through
      '{CH_BACKSLASH, 1'b0, 1'b1, 3'd0, 32'h0},
      '{CH_U,         1'b0, 1'b1, 3'd0, 32'h0},
      '{"F",          1'b0, 1'b1, 3'd0, 32'h0},
      '{"f",          1'b0, 1'b1, 3'd0, 32'h0},
      '{"f",          1'b0, 1'b1, 3'd0, 32'h0},
      '{"F",          1'b0, 1'b0, 3'd0, 32'h0},          // largest code, three bytes
      '{CH_BACKSLASH, 1'b0, 1'b1, 3'd0, 32'h0},
      '{CH_U,         1'b0, 1'b1, 3'd0, 32'h0},
      '{"4",          1'b0, 1'b1, 3'd0, 32'h0},
      '{"x",          1'b0, 1'b1, 3'd0, 32'h0},
      '{"1",          1'b0, 1'b1, 3'd0, 32'h0},
      '{"2",          1'b0, 1'b1, 3'd1, 32'h0000_0004},  // value stops at the x
      '{CH_BACKSLASH, 1'b0, 1'b1, 3'd0, 32'h0},
      '{CH_U,         1'b0, 1'b1, 3'd0, 32'h0},
      '{"a",          1'b0, 1'b1, 3'd0, 32'h0},
      '{"b",          1'b1, 1'b1, 3'd3, 32'h0062_6175},  // short group: u, then a b again
      '{CH_BACKSLASH, 1'b0, 1'b1, 3'd0, 32'h0},
      '{CH_U,         1'b1, 1'b1, 3'd1, 32'h0000_0075},  // escape u as last byte
      '{CH_BACKSLASH, 1'b1, 1'b1, 3'd1, 32'h0000_005C}   // lone trailing backslash
   };

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_payload;
   logic            csr_valid;
   logic            csr_ready;
   logic [15:0]     csr_wdata;

   // predictor state
   logic [15:0]     limit_reg = 16'hFFFF;
   parse_mode_type  mode;
   int unsigned     hex_count;
   logic [7:0]      hex_chars [4];
   logic [15:0]     code_acc;
   logic            hex_ok;
   int unsigned     out_count;

   rsp_payload_type new_plain [$];
   rsp_payload_type pending_plain [$];
   rsp_payload_type oldest_plain;
   logic [7:0]      plan_byte [$];
   logic            plan_end [$];

   int fail_count  = 0;
   int idle_cycles = 0;
   bit calm        = 1'b0;
   bit hold_output = 1'b0;

   json_string_unescape_utf8_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // predictor helpers
   function automatic int hex_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      return -1;
   endfunction

   function automatic void emit(input logic [7:0] v);
      new_plain.push_back('{plain_byte: v, final_mark: 1'b0});
      out_count++;
   endfunction

   function automatic void clear_text_state();
      mode      = MODE_TEXT;
      hex_count = 0;
      code_acc  = '0;
      hex_ok    = 1'b1;
      out_count = 0;
   endfunction

   // byte limit in effect: register clipped to what the counter holds
   function automatic int unsigned cap_now();
      longint unsigned widest;
      widest = (64'd1 << COUNT_WIDTH) - 1;
      return (64'(limit_reg) < widest) ? int'(limit_reg) : int'(widest);
   endfunction

   // unescape one input word into new_plain; a short hex group is replayed as text
   function automatic void unescape_word(input logic [7:0] b, input logic e);
      logic [7:0]  todo_b [$];
      logic        todo_e [$];
      logic [7:0]  c;
      logic        ce;
      int          d;
      int          k;
      int          n;
      logic [15:0] cp;
      int unsigned cap;
      new_plain.delete();
      cap = cap_now();
      todo_b.push_back(b);
      todo_e.push_back(e);
      while (todo_b.size() > 0) begin
         c  = todo_b.pop_front();
         ce = todo_e.pop_front();
         case (mode)
            MODE_ESCAPE: begin
               mode = MODE_TEXT;
               case (c)
                  CH_QUOTE:     emit(CH_QUOTE);
                  CH_BACKSLASH: emit(CH_BACKSLASH);
                  "b":          emit(CTL_BACKSPACE);
                  "f":          emit(CTL_FORMFEED);
                  "n":          emit(CTL_NEWLINE);
                  "r":          emit(CTL_RETURN);
                  "t":          emit(CTL_TAB);
                  CH_U: begin
                     if (ce) begin
                        emit(CH_U);
                     end else begin
                        mode      = MODE_HEX;
                        hex_count = 0;
                        code_acc  = '0;
                        hex_ok    = 1'b1;
                     end
                  end
                  default:      emit(c);
               endcase
            end
            MODE_HEX: begin
               d = hex_value(c);
               hex_chars[hex_count[1:0]] = c;
               if (hex_ok && d >= 0) code_acc = {code_acc[11:0], d[3:0]};
               else hex_ok = 1'b0;
               hex_count++;
               if (hex_count >= 4) begin
                  cp        = code_acc;
                  mode      = MODE_TEXT;
                  hex_count = 0;
                  if (cp < 16'h80) begin
                     emit(cp[7:0]);
                  end else if (cp < 16'h800) begin
                     if (out_count + 1 < cap) begin
                        emit({3'b110, cp[10:6]});
                        emit({2'b10, cp[5:0]});
                     end
                  end else if (out_count + 2 < cap) begin
                     emit({4'b1110, cp[15:12]});
                     emit({2'b10, cp[11:6]});
                     emit({2'b10, cp[5:0]});
                  end
               end else if (ce) begin
                  n         = hex_count;
                  mode      = MODE_TEXT;
                  hex_count = 0;
                  emit(CH_U);
                  for (k = 0; k < n; k++) begin
                     todo_b.push_back(hex_chars[k]);
                     todo_e.push_back(k == n - 1);
                  end
               end
            end
            default: begin
               mode = MODE_TEXT;
               if (out_count < cap) begin
                  if (c == CH_BACKSLASH && !ce) mode = MODE_ESCAPE;
                  else emit(c);
               end
            end
         endcase
      end
      if (e) begin
         new_plain.push_back(TERMINATOR);
         clear_text_state();
      end
   endfunction

   // stimulus helpers
   function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
      if (v < 4'd10) return 8'("0") + 8'(v);
      return (upper ? 8'("A") : 8'("a")) + 8'(v) - 8'd10;
   endfunction

   // one string of random tokens, sometimes cut short, possibly inside an escape
   function automatic void add_string();
      logic [7:0]  s [$];
      logic [7:0]  esc_set [8];
      logic [7:0]  pick;
      logic [15:0] cp;
      int          r;
      int          k;
      int          cut;
      esc_set = '{CH_QUOTE, CH_BACKSLASH, CH_SLASH, "b", "f", "n", "r", "t"};
      repeat ($urandom_range(1, 6)) begin
         r = $urandom_range(0, 99);
         if (r < 40) begin
            pick = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(32, 126))
                                              : 8'($urandom_range(0, 255));
            s.push_back((pick == CH_BACKSLASH) ? "A" : pick);
         end else if (r < 60) begin
            s.push_back(CH_BACKSLASH);
            s.push_back(($urandom_range(0, 9) < 8) ? esc_set[$urandom_range(0, 7)]
                                                   : 8'($urandom_range(0, 255)));
         end else if (r < 90) begin
            k = $urandom_range(0, 99);
            if (k < 35)      cp = 16'($urandom_range(0, 16'h7F));
            else if (k < 65) cp = 16'($urandom_range(16'h80, 16'h7FF));
            else             cp = 16'($urandom_range(16'h800, 16'hFFFF));
            s.push_back(CH_BACKSLASH);
            s.push_back(CH_U);
            for (k = 3; k >= 0; k--) s.push_back(hex_char(cp[4*k +: 4], $urandom_range(0, 1)));
            // spoil one character of the group now and then
            if ($urandom_range(0, 99) < 15) s[s.size() - 1 - $urandom_range(0, 3)] =
                                              8'($urandom_range(0, 255));
         end else begin
            s.push_back(8'($urandom_range(0, 255)));
         end
      end
      if ($urandom_range(0, 99) < 15) begin
         cut = $urandom_range(1, s.size());
         while (s.size() > cut) void'(s.pop_back());
      end
      foreach (s[i]) begin
         plan_byte.push_back(s[i]);
         plan_end.push_back(i == s.size() - 1);
      end
   endfunction

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   // offer one word and wait until it is taken
   task automatic offer_word(input logic [7:0] b, input logic e);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_payload <= '{text_byte: b, text_end: e};
      req_valid   <= 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_plain.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [15:0] v);
      @(negedge clock);
      csr_wdata <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (csr_ready !== 1'b1);
      limit_reg = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [15:0] phase_limit(input int phase);
      case (phase)
         1:       return 16'd0;
         2:       return 16'd1;
         3:       return 16'd2;
         4:       return 16'd3;
         5:       return 16'($urandom_range(4, 16));
         default: return 16'hFFFF;
      endcase
   endfunction

   // main sequence
   initial begin
      logic [7:0] b;
      logic       e;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_valid   = 1'b0;
      csr_wdata   = '0;
      clear_text_state();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed words at the reset limit
      foreach (PROBES[i]) begin
         offer_word(PROBES[i].text_byte, PROBES[i].text_end);
         unescape_word(PROBES[i].text_byte, PROBES[i].text_end);
         if (PROBES[i].given) begin
            new_plain.delete();
            for (int k = 0; k < PROBES[i].n; k++)
               new_plain.push_back('{plain_byte: PROBES[i].want[8*k +: 8], final_mark: 1'b0});
            if (PROBES[i].text_end) new_plain.push_back(TERMINATOR);
         end
         foreach (new_plain[j]) pending_plain.push_back(new_plain[j]);
      end

      // random strings, one limit setting per phase
      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            settle();
            write_limit(phase_limit(phase));
         end
         calm = (phase == 2) || ($urandom_range(0, 4) == 0);
         if (phase == 0) hold_output = 1'b1;
         while (plan_byte.size() < PHASE_WORDS) add_string();
         while (plan_byte.size() > 0) begin
            b = plan_byte.pop_front();
            e = plan_end.pop_front();
            offer_word(b, e);
            unescape_word(b, e);
            foreach (new_plain[j]) pending_plain.push_back(new_plain[j]);
         end
      end

      settle();
      if (fail_count == 0 && pending_plain.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // output side stalls: short and long, one long hold-off on request
   initial begin
      int r;
      int stall_left;
      stall_left = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_output) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_output = 1'b0;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (calm) begin
            rsp_stall <= 1'b0;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               rsp_stall <= 1'b0;
            end else begin
               rsp_stall  <= 1'b1;
               stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 30);
            end
         end
      end
   end

   // compare each taken result word with the oldest expected one
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_plain.size() == 0) begin
            $error("unexpected word: plain_byte %02h final_mark %0b",
                   rsp_payload.plain_byte, rsp_payload.final_mark);
            fail_count++;
         end else begin
            oldest_plain = pending_plain.pop_front();
            if (rsp_payload.plain_byte !== oldest_plain.plain_byte) begin
               $error("plain_byte: expected %02h, actual %02h",
                      oldest_plain.plain_byte, rsp_payload.plain_byte);
               fail_count++;
            end
            if (rsp_payload.final_mark !== oldest_plain.final_mark) begin
               $error("final_mark: expected %0b, actual %0b",
                      oldest_plain.final_mark, rsp_payload.final_mark);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles with no handshake on any port
   always @(posedge clock) begin
      if (reset === 1'b1 || (req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0) ||
          (csr_valid === 1'b1 && csr_ready === 1'b1)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

endmodule
